### hdl/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, masked while reset is high
`define CPI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also holds through reset
`define CPI_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/cpi_pkg.sv
`timescale 1ns / 1ps
package cpi_pkg;

   localparam int VIEW_SLOTS_DEF = 4;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_CUT_DISTANCE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CUT_MIN_DOT  = 1'd1;

   localparam logic [19:0]        CUT_DISTANCE_RST = 20'd16000;
   localparam logic signed [15:0] CUT_MIN_DOT_RST  = 16'sd14189;

   localparam logic [1:0] MODE_CAPTURE = 2'd0;
   localparam logic [1:0] MODE_APPLY   = 2'd1;
   localparam logic [1:0] MODE_CLEAR   = 2'd2;

   localparam logic [16:0] ALPHA_ONE = 17'd65536;

   typedef logic signed [21:0] c22_type;
   typedef c22_type [2:0] v22_type;
   typedef logic signed [17:0] c18_type;
   typedef c18_type [2:0] v18_type;

   typedef struct packed {
      logic [62:0] pos;
      logic [62:0] look_at;
      logic [47:0] up;
      logic [15:0] fovy;
   } pose_type;

   typedef struct packed {
      pose_type prev;
      pose_type curr;
   } entry_type;

   typedef struct packed {
      logic    start;
      v22_type vec;
   } norm_req_type;

   typedef struct packed {
      logic    done;
      v18_type n;
   } norm_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIST,
      ST_NORM_A,
      ST_NORM_B,
      ST_DOT,
      ST_CAP_WR,
      ST_BLEND,
      ST_NORM_UP,
      ST_OUT
   } seq_state_type;

   typedef enum logic [2:0] {
      N_IDLE,
      N_SQ,
      N_SQRT,
      N_LOAD,
      N_DIV
   } norm_state_type;

   function automatic c22_type get21(logic [62:0] p, logic [1:0] k);
      return c22_type'($signed(p[21*k +: 21]));
   endfunction

   function automatic c22_type get16(logic [47:0] p, logic [1:0] k);
      return c22_type'($signed(p[16*k +: 16]));
   endfunction

   // blend operand j: three position, three look-at, three up, then fovy
   function automatic c22_type blend_src(pose_type p, logic [3:0] j);
      c22_type r;
      case (j)
         4'd0, 4'd1, 4'd2: r = get21(p.pos, j[1:0]);
         4'd3:             r = get21(p.look_at, 2'd0);
         4'd4:             r = get21(p.look_at, 2'd1);
         4'd5:             r = get21(p.look_at, 2'd2);
         4'd6:             r = get16(p.up, 2'd0);
         4'd7:             r = get16(p.up, 2'd1);
         4'd8:             r = get16(p.up, 2'd2);
         default:          r = c22_type'({6'd0, p.fovy});
      endcase
      return r;
   endfunction

   function automatic logic [15:0] sat16(c18_type v);
      logic [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'h7fff;
      end else if (v < -18'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

### hdl/cpi_if.sv
`timescale 1ns / 1ps
interface cpi_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [1:0]  view_index;
   logic [7:0]  source_tag;
   logic [62:0] pos;
   logic [62:0] look_at;
   logic [47:0] up_vec;
   logic [15:0] fovy;
   logic [16:0] alpha;

   modport source (output valid, mode, view_index, source_tag, pos, look_at, up_vec, fovy,
                   alpha, input ready);
   modport sink (input valid, mode, view_index, source_tag, pos, look_at, up_vec, fovy,
                 alpha, output ready);
endinterface

interface cpi_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  out_view;
   logic [62:0] out_pos;
   logic [62:0] out_look_at;
   logic [47:0] out_up;
   logic [15:0] out_fovy;
   logic        fovy_blended;

   modport source (output valid, out_view, out_pos, out_look_at, out_up, out_fovy,
                   fovy_blended, input ready);
   modport sink (input valid, out_view, out_pos, out_look_at, out_up, out_fovy,
                 fovy_blended, output ready);
endinterface

### hdl/cpi_norm.sv
`timescale 1ns / 1ps
module cpi_norm import cpi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  norm_req_type req,
   output norm_rsp_type rsp
);

   norm_state_type     st_ff, st_in;
   v22_type            vec_ff, vec_in;
   logic [1:0]         k_ff, k_in;
   logic signed [43:0] prod_ff, prod_in;
   logic [45:0]        sum_ff, sum_in;
   logic [45:0]        rem_ff, rem_in;
   logic [45:0]        root_ff, root_in;
   logic [45:0]        bit_ff, bit_in;
   logic [22:0]        len_ff, len_in;
   logic [35:0]        drem_ff, drem_in;
   logic [38:0]        dsh_ff, dsh_in;
   logic [16:0]        q_ff, q_in;
   logic [4:0]         it_ff, it_in;
   v18_type            n_ff, n_in;
   logic               done_ff, done_in;

   logic [45:0] sum_fin;
   logic [46:0] trial;
   logic [21:0] mag;
   logic        ge;
   logic [16:0] q_next;
   logic [1:0]  sq_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= N_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      vec_ff  <= vec_in;
      k_ff    <= k_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      len_ff  <= len_in;
      drem_ff <= drem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
      it_ff   <= it_in;
      n_ff    <= n_in;
   end

   always_comb begin
      st_in   = st_ff;
      vec_in  = vec_ff;
      k_in    = k_ff;
      prod_in = prod_ff;
      sum_in  = sum_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      len_in  = len_ff;
      drem_in = drem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      it_in   = it_ff;
      n_in    = n_ff;
      done_in = 1'b0;
      sq_sel  = (k_ff == 2'd3) ? 2'd0 : k_ff;
      sum_fin = sum_ff + 46'($unsigned(prod_ff));
      trial   = 47'(root_ff) + 47'(bit_ff);
      mag     = vec_ff[k_ff[1:0]][21] ? 22'(-vec_ff[k_ff]) : 22'(vec_ff[k_ff]);
      ge      = {3'd0, drem_ff} >= dsh_ff;
      q_next  = {q_ff[15:0], ge};
      unique case (st_ff)
         N_IDLE: begin
            if (req.start) begin
               vec_in = req.vec;
               k_in   = 2'd0;
               sum_in = '0;
               st_in  = N_SQ;
            end
         end
         N_SQ: begin
            prod_in = vec_ff[sq_sel] * vec_ff[sq_sel];
            if (k_ff != 2'd0) begin
               sum_in = sum_fin;
            end
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               if (sum_fin == '0) begin
                  n_in    = '0;
                  done_in = 1'b1;
                  st_in   = N_IDLE;
               end else begin
                  rem_in  = sum_fin;
                  root_in = '0;
                  bit_in  = 46'(1) << 44;
                  st_in   = N_SQRT;
               end
            end
         end
         N_SQRT: begin
            // one bit pair of the root per cycle, then round to nearest
            if (bit_ff == '0) begin
               len_in = 23'(root_ff + ((rem_ff > root_ff) ? 46'd1 : 46'd0));
               k_in   = 2'd0;
               st_in  = N_LOAD;
            end else begin
               if ({1'b0, rem_ff} >= trial) begin
                  rem_in  = rem_ff - trial[45:0];
                  root_in = (root_ff >> 1) + bit_ff;
               end else begin
                  root_in = root_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
         end
         N_LOAD: begin
            drem_in = {mag, 14'd0} + 36'(len_ff >> 1);
            dsh_in  = {len_ff, 16'd0};
            q_in    = '0;
            it_in   = '0;
            st_in   = N_DIV;
         end
         N_DIV: begin
            if (ge) begin
               drem_in = drem_ff - dsh_ff[35:0];
            end
            q_in   = q_next;
            dsh_in = dsh_ff >> 1;
            it_in  = it_ff + 5'd1;
            if (it_ff == 5'd16) begin
               n_in[k_ff] = vec_ff[k_ff][21] ? -c18_type'({1'b0, q_next})
                                             : c18_type'({1'b0, q_next});
               if (k_ff == 2'd2) begin
                  done_in = 1'b1;
                  st_in   = N_IDLE;
               end else begin
                  k_in  = k_ff + 2'd1;
                  st_in = N_LOAD;
               end
            end
         end
         default: st_in = N_IDLE;
      endcase
   end

   assign rsp.done = done_ff;
   assign rsp.n    = n_ff;

endmodule

### hdl/camera_pose_interpolator.sv
`timescale 1ns / 1ps
// Camera pose interpolator: previous and current pose per view slot.
// req_ch carries one request: capture stores a pose, apply asks for the blend
// of previous and current pose by alpha, clear drops every slot. Only an apply
// to a valid slot with a matching source tag gives a response on rsp_ch.
// csr_we/csr_index/csr_wdata write the cut distance (index 0) and the least
// direction dot product (index 1); write them only while the block is idle.
// One request is worked at a time; req_ch.ready is high only when idle.
// Clear, unknown mode and out-of-range slot requests end at acceptance. A capture
// that misses is written back right after the check; one that hits runs the cut
// test first, and an apply normalizes the blended up vector. Both use the shared
// normalizer: a square root with one bit pair per cycle and a divide with one
// quotient bit per cycle for each of the three components.
// The slot state sits in a one-port memory read at acceptance and written
// back in the last cycle of a capture.
// The response waits in an output register; a stalled rsp_ch holds it and
// the block can take the next request meanwhile, stalling only when a newer
// response is ready. Synchronous reset invalidates every slot, loads the
// register defaults and drops any pending response.
module camera_pose_interpolator import cpi_pkg::*; #(
   parameter int VIEW_SLOTS = VIEW_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   cpi_req_if.sink               req_ch,
   cpi_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (VIEW_SLOTS > 1) ? $clog2(VIEW_SLOTS) : 1;

   entry_type mem [VIEW_SLOTS];
   entry_type rd_ff;
   entry_type wdata;
   logic      mem_we;

   logic [VIEW_SLOTS-1:0] valid_ff;
   logic [7:0]            tagm_ff [VIEW_SLOTS];

   logic [19:0]        cut_dist_ff;
   logic signed [15:0] cut_dot_ff;

   logic [1:0]  it_mode_ff;
   logic [1:0]  it_view_ff;
   logic [7:0]  it_tag_ff;
   logic [62:0] it_pos_ff;
   logic [62:0] it_look_ff;
   logic [47:0] it_up_ff;
   logic [15:0] it_fovy_ff;
   logic [16:0] it_alpha_ff;

   seq_state_type      state_ff, state_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic signed [47:0] acc_ff, acc_in;
   logic signed [47:0] prod_ff, prod_in;
   logic               cut_ff, cut_in;
   v18_type            na_ff, na_in;
   c22_type            bres_ff [10];
   c22_type            bres_in [10];

   logic               rsp_valid_ff;
   logic [1:0]         rsp_view_ff;
   logic [62:0]        rsp_pos_ff;
   logic [62:0]        rsp_look_ff;
   logic [47:0]        rsp_up_ff;
   logic [15:0]        rsp_fovy_ff;
   logic               rsp_blend_ff;
   logic               load_out;

   logic               accept;
   logic               in_range;
   logic [IDX_W-1:0]   req_idx;
   logic [IDX_W-1:0]   it_idx;
   logic               hit;
   logic signed [23:0] mul_a;
   logic signed [23:0] mul_b;
   c22_type            pv;
   c22_type            cv;
   c22_type            pv_last;
   logic signed [47:0] q48;
   logic signed [23:0] bsum;
   logic signed [47:0] dot;
   logic signed [47:0] dot_min;
   v22_type            da;
   v22_type            db;
   norm_req_type       norm_req;
   norm_rsp_type       norm_rsp;

   assign accept   = req_ch.valid && req_ch.ready;
   assign in_range = {3'd0, req_ch.view_index} < 5'(VIEW_SLOTS);
   assign req_idx  = IDX_W'(req_ch.view_index);
   assign it_idx   = IDX_W'(it_view_ff);
   assign hit      = valid_ff[it_idx] && (tagm_ff[it_idx] == it_tag_ff);
   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         da[i] = get21(rd_ff.curr.look_at, 2'(i)) - get21(rd_ff.curr.pos, 2'(i));
         db[i] = get21(it_look_ff, 2'(i)) - get21(it_pos_ff, 2'(i));
      end
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cut_dist_ff <= CUT_DISTANCE_RST;
         cut_dot_ff  <= CUT_MIN_DOT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CUT_DISTANCE: cut_dist_ff <= csr_wdata;
            CSR_CUT_MIN_DOT:  cut_dot_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // slot memory: read at acceptance, written at the end of a capture
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[it_idx] <= wdata;
      end
      if (accept) begin
         rd_ff <= mem[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < VIEW_SLOTS; i++) begin
            tagm_ff[i] <= '0;
         end
      end else if (accept && req_ch.mode == MODE_CLEAR) begin
         valid_ff <= '0;
         for (int i = 0; i < VIEW_SLOTS; i++) begin
            tagm_ff[i] <= '0;
         end
      end else if (mem_we) begin
         valid_ff[it_idx] <= 1'b1;
         tagm_ff[it_idx]  <= it_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         it_mode_ff  <= req_ch.mode;
         it_view_ff  <= req_ch.view_index;
         it_tag_ff   <= req_ch.source_tag;
         it_pos_ff   <= req_ch.pos;
         it_look_ff  <= req_ch.look_at;
         it_up_ff    <= req_ch.up_vec;
         it_fovy_ff  <= req_ch.fovy;
         it_alpha_ff <= (req_ch.alpha > ALPHA_ONE) ? ALPHA_ONE : req_ch.alpha;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      cut_ff  <= cut_in;
      na_ff   <= na_in;
      bres_ff <= bres_in;
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      cut_in   = cut_ff;
      na_in    = na_ff;
      bres_in  = bres_ff;
      mul_a    = '0;
      mul_b    = '0;
      mem_we   = 1'b0;
      load_out = 1'b0;
      norm_req = '0;
      wdata.curr = '{pos: it_pos_ff, look_at: it_look_ff, up: it_up_ff, fovy: it_fovy_ff};
      wdata.prev = cut_ff ? wdata.curr : rd_ff.curr;
      pv      = blend_src(rd_ff.prev, cnt_ff);
      cv      = blend_src(rd_ff.curr, cnt_ff);
      pv_last = blend_src(rd_ff.prev, 4'(cnt_ff - 4'd1));
      q48     = (prod_ff + 48'sd32768) >>> 16;
      bsum    = 24'(pv_last) + q48[23:0];
      dot     = acc_ff + prod_ff;
      dot_min = {{18{cut_dot_ff[15]}}, cut_dot_ff, 14'd0};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && in_range &&
                (req_ch.mode == MODE_CAPTURE || req_ch.mode == MODE_APPLY)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cnt_in = '0;
            acc_in = '0;
            cut_in = 1'b0;
            if (it_mode_ff == MODE_CAPTURE) begin
               if (hit) begin
                  state_in = ST_DIST;
               end else begin
                  cut_in   = 1'b1;
                  state_in = ST_CAP_WR;
               end
            end else begin
               state_in = hit ? ST_BLEND : ST_IDLE;
            end
         end
         ST_DIST: begin
            // squared jump, then squared cut distance for the compare
            if (cnt_ff < 4'd3) begin
               mul_a = 24'(get21(it_pos_ff, cnt_ff[1:0]))
                     - 24'(get21(rd_ff.curr.pos, cnt_ff[1:0]));
               mul_b = mul_a;
            end else begin
               mul_a = 24'(cut_dist_ff);
               mul_b = 24'(cut_dist_ff);
            end
            if (cnt_ff != 4'd0 && cnt_ff != 4'd4) begin
               acc_in = acc_ff + prod_ff;
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd4) begin
               if (acc_ff > prod_ff) begin
                  cut_in   = 1'b1;
                  state_in = ST_CAP_WR;
               end else begin
                  norm_req.start = 1'b1;
                  norm_req.vec   = da;
                  state_in       = ST_NORM_A;
               end
            end
         end
         ST_NORM_A: begin
            if (norm_rsp.done) begin
               na_in          = norm_rsp.n;
               norm_req.start = 1'b1;
               norm_req.vec   = db;
               state_in       = ST_NORM_B;
            end
         end
         ST_NORM_B: begin
            if (norm_rsp.done) begin
               cnt_in   = '0;
               acc_in   = '0;
               state_in = ST_DOT;
            end
         end
         ST_DOT: begin
            if (cnt_ff < 4'd3) begin
               mul_a = 24'(na_ff[cnt_ff[1:0]]);
               mul_b = 24'(norm_rsp.n[cnt_ff[1:0]]);
            end
            if (cnt_ff != 4'd0) begin
               acc_in = dot;
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd3) begin
               cut_in   = dot < dot_min;
               state_in = ST_CAP_WR;
            end
         end
         ST_CAP_WR: begin
            mem_we   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_BLEND: begin
            // one blend product per cycle, result folded in on the cycle after
            if (cnt_ff < 4'd10) begin
               mul_a = 24'(cv) - 24'(pv);
               mul_b = 24'({1'b0, it_alpha_ff});
            end
            if (cnt_ff != 4'd0) begin
               bres_in[4'(cnt_ff - 4'd1)] = bsum[21:0];
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd10) begin
               norm_req.start = 1'b1;
               norm_req.vec   = {bres_ff[8], bres_ff[7], bres_ff[6]};
               state_in       = ST_NORM_UP;
            end
         end
         ST_NORM_UP: begin
            if (norm_rsp.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   cpi_norm u_norm (
      .clock (clock),
      .reset (reset),
      .req   (norm_req),
      .rsp   (norm_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_out) begin
         rsp_view_ff <= it_view_ff;
         rsp_pos_ff  <= {bres_ff[2][20:0], bres_ff[1][20:0], bres_ff[0][20:0]};
         rsp_look_ff <= {bres_ff[5][20:0], bres_ff[4][20:0], bres_ff[3][20:0]};
         rsp_up_ff   <= {sat16(norm_rsp.n[2]), sat16(norm_rsp.n[1]), sat16(norm_rsp.n[0])};
         if (rd_ff.prev.fovy != rd_ff.curr.fovy) begin
            rsp_fovy_ff  <= bres_ff[9][15:0];
            rsp_blend_ff <= 1'b1;
         end else begin
            rsp_fovy_ff  <= rd_ff.curr.fovy;
            rsp_blend_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_view     = rsp_view_ff;
   assign rsp_ch.out_pos      = rsp_pos_ff;
   assign rsp_ch.out_look_at  = rsp_look_ff;
   assign rsp_ch.out_up       = rsp_up_ff;
   assign rsp_ch.out_fovy     = rsp_fovy_ff;
   assign rsp_ch.fovy_blended = rsp_blend_ff;

endmodule

### hdl/cpi_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cpi_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // a stalled response stays offered
   `CPI_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")

   // reset leaves the block ready for a request
   `CPI_ASSERT_ALWAYS(a_reset_ready, clock, reset |=> req_ready, "not ready after reset")

   // reset leaves no response pending
   `CPI_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "response pending after reset")

endmodule

bind camera_pose_interpolator cpi_checker u_cpi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready)
);
